// File: hw/rtl/uniform_grid_spatial_index_assert.svh
// assertion macros used by the checker of the grid index
`ifndef UNIFORM_GRID_SPATIAL_INDEX_ASSERT_SVH
`define UNIFORM_GRID_SPATIAL_INDEX_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define UGSI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid index check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define UGSI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid index check failed");

`endif

// File: hw/rtl/ugsi_pkg.sv
`timescale 1ns / 1ps
package ugsi_pkg;

    localparam int ROWS_DEFAULT    = 20;
    localparam int COLS_DEFAULT    = 30;
    localparam int MAX_OBJ_DEFAULT = 32;
    localparam int MASK_W          = 32;
    localparam int COORD_W         = 32;
    localparam int CFG_IDX_W       = 2;

    localparam logic [2:0] CMD_ADD_RECT   = 3'd0;
    localparam logic [2:0] CMD_ADD_LINE   = 3'd1;
    localparam logic [2:0] CMD_DEL_LINE   = 3'd2;
    localparam logic [2:0] CMD_QUERY_RECT = 3'd3;
    localparam logic [2:0] CMD_QUERY_LINE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MAX_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MIN_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MAX_Y = 2'd3;

    localparam logic [1:0] CORNER_MIN_X = 2'd0;
    localparam logic [1:0] CORNER_MAX_X = 2'd1;
    localparam logic [1:0] CORNER_MIN_Y = 2'd2;
    localparam logic [1:0] CORNER_MAX_Y = 2'd3;

    typedef struct packed {
        logic [2:0]                 command;
        logic [4:0]                 object_id;
        logic signed [COORD_W-1:0]  box_min_x;
        logic signed [COORD_W-1:0]  box_max_x;
        logic signed [COORD_W-1:0]  box_min_y;
        logic signed [COORD_W-1:0]  box_max_y;
    } ugsi_in_t;

    typedef struct packed {
        logic [4:0] found_id;
        logic       found;
        logic       is_last;
    } ugsi_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_MAP_WAIT,
        ST_INIT,
        ST_READ,
        ST_MOD,
        ST_PICK,
        ST_SCAN,
        ST_EMPTY
    } ugsi_state_t;

    typedef struct packed {
        logic       clear_we;
        logic       load_item;
        logic       div_start;
        logic       div_store;
        logic [1:0] div_sel;
        logic       range_init;
        logic       cell_mod;
        logic       scan_shift;
        logic       scan_emit;
        logic       emit_empty;
    } ugsi_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic ignore;
        logic is_query;
        logic div_done;
        logic range_empty;
        logic cell_last;
        logic acc_zero;
        logic acc_bit;
        logic scan_last;
        logic can_load;
    } ugsi_status_t;

endpackage

// File: hw/rtl/ugsi_ram.sv
`timescale 1ns / 1ps
module ugsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 600
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/ugsi_div.sv
`timescale 1ns / 1ps
// maps one coordinate to a grid index: scale, clamp, restoring divide
module ugsi_div #(
    parameter int IW = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ugsi_pkg::COORD_W-1:0] p,
    input  logic signed [ugsi_pkg::COORD_W-1:0] lo,
    input  logic signed [ugsi_pkg::COORD_W-1:0] hi,
    input  logic [IW:0]                         n,
    output logic                                done,
    output logic [IW-1:0]                       idx
);

    localparam int CW = ugsi_pkg::COORD_W;
    localparam int NW = CW + IW;
    localparam int KW = (IW > 1) ? $clog2(IW) : 1;

    logic signed [CW:0] diff;
    logic signed [CW:0] den;
    logic [CW+IW:0]     prod;
    logic [NW-1:0]      rem_reg, rem_next;
    logic [NW-1:0]      dsh_reg, dsh_next;
    logic [CW-1:0]      diff_reg, diff_next;
    logic [CW-1:0]      den_reg, den_next;
    logic [IW:0]        n_reg, n_next;
    logic [IW-1:0]      q_reg, q_next;
    logic [KW-1:0]      cnt_reg, cnt_next;
    logic               mul_reg, mul_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic               ge;

    assign diff = (CW+1)'(p) - (CW+1)'(lo);
    assign den  = (CW+1)'(hi) - (CW+1)'(lo);
    assign prod = (CW+IW+1)'(diff_reg) * (CW+IW+1)'(n_reg);
    assign ge   = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        diff_next = diff_reg;
        den_next  = den_reg;
        n_next    = n_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        mul_next  = 1'b0;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            diff_next = diff[CW-1:0];
            den_next  = den[CW-1:0];
            n_next    = n;
            if (den <= 0 || diff < 0)
            begin
                q_next    = '0;
                done_next = 1'b1;
            end
            else if (diff >= den)
            begin
                q_next    = IW'(n - 1'b1);
                done_next = 1'b1;
            end
            else
            begin
                mul_next = 1'b1;
            end
        end
        else if (mul_reg)
        begin
            rem_next = prod[NW-1:0];
            dsh_next = NW'(den_reg) << (IW - 1);
            cnt_next = KW'(IW - 1);
            q_next   = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = IW'({q_reg, ge});
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= mul_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        diff_reg <= diff_next;
        den_reg  <= den_next;
        n_reg    <= n_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign idx  = q_reg;

endmodule

// File: hw/rtl/ugsi_dp.sv
`timescale 1ns / 1ps
module ugsi_dp #(
    parameter int ROWS        = ugsi_pkg::ROWS_DEFAULT,
    parameter int COLS        = ugsi_pkg::COLS_DEFAULT,
    parameter int MAX_OBJECTS = ugsi_pkg::MAX_OBJ_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ugsi_pkg::ugsi_cmd_t                  cmd,
    output ugsi_pkg::ugsi_status_t               status,
    input  ugsi_pkg::ugsi_in_t                   in_word,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output ugsi_pkg::ugsi_out_t                  out_word,
    input  logic                                 cfg_we,
    input  logic [ugsi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ugsi_pkg::COORD_W-1:0]         cfg_data
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int IW    = (RW > CW) ? RW : CW;
    localparam int MW    = ugsi_pkg::MASK_W;
    localparam int XW    = ugsi_pkg::COORD_W;

    // world window
    logic signed [XW-1:0] wminx_reg, wmaxx_reg, wminy_reg, wmaxy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wminx_reg <= '0;
            wmaxx_reg <= XW'(65536);
            wminy_reg <= '0;
            wmaxy_reg <= XW'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ugsi_pkg::REG_WORLD_MIN_X: wminx_reg <= cfg_data;
                ugsi_pkg::REG_WORLD_MAX_X: wmaxx_reg <= cfg_data;
                ugsi_pkg::REG_WORLD_MIN_Y: wminy_reg <= cfg_data;
                ugsi_pkg::REG_WORLD_MAX_Y: wmaxy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // item latch
    ugsi_pkg::ugsi_in_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_word;
        end
    end

    logic is_update;
    assign is_update = (item_reg.command == ugsi_pkg::CMD_ADD_RECT)
                    || (item_reg.command == ugsi_pkg::CMD_ADD_LINE)
                    || (item_reg.command == ugsi_pkg::CMD_DEL_LINE);
    assign status.is_query = (item_reg.command == ugsi_pkg::CMD_QUERY_RECT)
                          || (item_reg.command == ugsi_pkg::CMD_QUERY_LINE);
    assign status.ignore = !(is_update || status.is_query)
                        || (is_update && (7'(item_reg.object_id) >= 7'(MAX_OBJECTS)));

    // corner mapping
    logic signed [XW-1:0] div_p, div_lo, div_hi;
    logic [IW:0]          div_n;
    logic [IW-1:0]        div_idx;

    always_comb
    begin
        unique case (cmd.div_sel)
            ugsi_pkg::CORNER_MIN_X:
            begin
                div_p = item_reg.box_min_x; div_lo = wminx_reg; div_hi = wmaxx_reg;
                div_n = (IW+1)'(ROWS);
            end
            ugsi_pkg::CORNER_MAX_X:
            begin
                div_p = item_reg.box_max_x; div_lo = wminx_reg; div_hi = wmaxx_reg;
                div_n = (IW+1)'(ROWS);
            end
            ugsi_pkg::CORNER_MIN_Y:
            begin
                div_p = item_reg.box_min_y; div_lo = wminy_reg; div_hi = wmaxy_reg;
                div_n = (IW+1)'(COLS);
            end
            default:
            begin
                div_p = item_reg.box_max_y; div_lo = wminy_reg; div_hi = wmaxy_reg;
                div_n = (IW+1)'(COLS);
            end
        endcase
    end

    ugsi_div #(.IW(IW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .p     (div_p),
        .lo    (div_lo),
        .hi    (div_hi),
        .n     (div_n),
        .done  (status.div_done),
        .idx   (div_idx)
    );

    logic [RW-1:0] r0_reg, r1_reg, r_reg;
    logic [CW-1:0] c0_reg, c1_reg, c_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            unique case (cmd.div_sel)
                ugsi_pkg::CORNER_MIN_X: r0_reg <= div_idx[RW-1:0];
                ugsi_pkg::CORNER_MAX_X: r1_reg <= div_idx[RW-1:0];
                ugsi_pkg::CORNER_MIN_Y: c0_reg <= div_idx[CW-1:0];
                default:                c1_reg <= div_idx[CW-1:0];
            endcase
        end
    end

    assign status.range_empty = (r0_reg > r1_reg) || (c0_reg > c1_reg);
    assign status.cell_last   = (r_reg == r1_reg) && (c_reg == c1_reg);

    // cell walk
    logic [AW-1:0] addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.range_init)
        begin
            r_reg    <= r0_reg;
            c_reg    <= c0_reg;
            addr_reg <= AW'(32'(r0_reg) * COLS + 32'(c0_reg));
        end
        else if (cmd.cell_mod)
        begin
            if (c_reg == c1_reg)
            begin
                r_reg    <= r_reg + 1'b1;
                c_reg    <= c0_reg;
                addr_reg <= AW'(32'(addr_reg) + COLS - 32'(c1_reg) + 32'(c0_reg));
            end
            else
            begin
                c_reg    <= c_reg + 1'b1;
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    // clearing pass after reset
    logic [AW-1:0] clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_we)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    assign status.clear_last = (32'(clr_reg) == CELLS - 1);

    // mask memories
    logic [MW-1:0] rect_rd, line_rd, sel_rd, bit_mask, upd_mask;
    logic          rect_we, line_we;
    logic [AW-1:0] waddr;
    logic [MW-1:0] wdata;

    assign sel_rd   = (item_reg.command == ugsi_pkg::CMD_ADD_RECT
                    || item_reg.command == ugsi_pkg::CMD_QUERY_RECT) ? rect_rd : line_rd;
    assign bit_mask = MW'(1) << item_reg.object_id;
    assign upd_mask = (item_reg.command == ugsi_pkg::CMD_DEL_LINE) ? (sel_rd & ~bit_mask)
                                                                   : (sel_rd | bit_mask);
    assign rect_we  = cmd.clear_we
                   || (cmd.cell_mod && item_reg.command == ugsi_pkg::CMD_ADD_RECT);
    assign line_we  = cmd.clear_we
                   || (cmd.cell_mod && (item_reg.command == ugsi_pkg::CMD_ADD_LINE
                                     || item_reg.command == ugsi_pkg::CMD_DEL_LINE));
    assign waddr    = cmd.clear_we ? clr_reg : addr_reg;
    assign wdata    = cmd.clear_we ? '0 : upd_mask;

    ugsi_ram #(.WIDTH(MW), .DEPTH(CELLS)) u_rect_ram (
        .clk   (clk),
        .we    (rect_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr_reg),
        .rdata (rect_rd)
    );

    ugsi_ram #(.WIDTH(MW), .DEPTH(CELLS)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr_reg),
        .rdata (line_rd)
    );

    // accumulate and scan
    logic [MW-1:0] acc_reg;
    logic [4:0]    k_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.range_init)
        begin
            acc_reg <= '0;
            k_reg   <= '0;
        end
        else if (cmd.cell_mod && status.is_query)
        begin
            acc_reg <= acc_reg | sel_rd;
        end
        else if (cmd.scan_shift)
        begin
            acc_reg <= acc_reg >> 1;
            k_reg   <= k_reg + 1'b1;
        end
    end

    assign status.acc_zero  = (acc_reg == '0);
    assign status.acc_bit   = acc_reg[0];
    assign status.scan_last = (acc_reg[MW-1:1] == '0);

    // output register
    logic                out_valid_reg;
    ugsi_pkg::ugsi_out_t out_reg;

    assign status.can_load = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.scan_emit || cmd.emit_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_emit)
        begin
            out_reg.found_id <= k_reg;
            out_reg.found    <= 1'b1;
            out_reg.is_last  <= status.scan_last;
        end
        else if (cmd.emit_empty)
        begin
            out_reg.found_id <= '0;
            out_reg.found    <= 1'b0;
            out_reg.is_last  <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

// File: hw/rtl/ugsi_ctrl.sv
`timescale 1ns / 1ps
module ugsi_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ugsi_pkg::ugsi_status_t status,
    output ugsi_pkg::ugsi_cmd_t    cmd
);

    ugsi_pkg::ugsi_state_t state_reg, state_next;
    logic [1:0]            corner_reg, corner_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ugsi_pkg::ST_CLEAR;
            corner_reg <= ugsi_pkg::CORNER_MIN_X;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        unique case (state_reg)
            ugsi_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ugsi_pkg::ST_IDLE;
                end
            end
            ugsi_pkg::ST_IDLE:
            begin
                corner_next = ugsi_pkg::CORNER_MIN_X;
                if (in_valid)
                begin
                    state_next = ugsi_pkg::ST_MAP;
                end
            end
            ugsi_pkg::ST_MAP:
            begin
                state_next = status.ignore ? ugsi_pkg::ST_IDLE : ugsi_pkg::ST_MAP_WAIT;
            end
            ugsi_pkg::ST_MAP_WAIT:
            begin
                if (status.div_done)
                begin
                    if (corner_reg == ugsi_pkg::CORNER_MAX_Y)
                    begin
                        state_next = ugsi_pkg::ST_INIT;
                    end
                    else
                    begin
                        state_next  = ugsi_pkg::ST_MAP;
                        corner_next = corner_reg + 1'b1;
                    end
                end
            end
            ugsi_pkg::ST_INIT:
            begin
                priority if (!status.range_empty)
                begin
                    state_next = ugsi_pkg::ST_READ;
                end
                else if (status.is_query)
                begin
                    state_next = ugsi_pkg::ST_EMPTY;
                end
                else
                begin
                    state_next = ugsi_pkg::ST_IDLE;
                end
            end
            ugsi_pkg::ST_READ:
            begin
                state_next = ugsi_pkg::ST_MOD;
            end
            ugsi_pkg::ST_MOD:
            begin
                priority if (!status.cell_last)
                begin
                    state_next = ugsi_pkg::ST_READ;
                end
                else if (status.is_query)
                begin
                    state_next = ugsi_pkg::ST_PICK;
                end
                else
                begin
                    state_next = ugsi_pkg::ST_IDLE;
                end
            end
            ugsi_pkg::ST_PICK:
            begin
                state_next = status.acc_zero ? ugsi_pkg::ST_EMPTY : ugsi_pkg::ST_SCAN;
            end
            ugsi_pkg::ST_SCAN:
            begin
                if (status.acc_bit && status.can_load && status.scan_last)
                begin
                    state_next = ugsi_pkg::ST_IDLE;
                end
            end
            ugsi_pkg::ST_EMPTY:
            begin
                if (status.can_load)
                begin
                    state_next = ugsi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ugsi_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = corner_reg;
        in_stall    = 1'b1;
        unique case (state_reg)
            ugsi_pkg::ST_CLEAR:    cmd.clear_we = 1'b1;
            ugsi_pkg::ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_item = in_valid;
            end
            ugsi_pkg::ST_MAP:      cmd.div_start  = !status.ignore;
            ugsi_pkg::ST_MAP_WAIT: cmd.div_store  = status.div_done;
            ugsi_pkg::ST_INIT:     cmd.range_init = 1'b1;
            ugsi_pkg::ST_READ:     ;
            ugsi_pkg::ST_MOD:      cmd.cell_mod   = 1'b1;
            ugsi_pkg::ST_PICK:     ;
            ugsi_pkg::ST_SCAN:
            begin
                cmd.scan_emit  = status.acc_bit && status.can_load;
                cmd.scan_shift = !status.acc_bit || status.can_load;
            end
            ugsi_pkg::ST_EMPTY:    cmd.emit_empty = status.can_load;
            default: ;
        endcase
    end

endmodule

// File: hw/rtl/uniform_grid_spatial_index.sv
// four corner maps on one shared divider, then per covered cell a registered ram
//   read, then a write or OR; queries then scan the 32-bit id mask, one bit a cycle
//   unless the output stalls, one word out per set bit, or one miss word if none
// one item at a time: input is stalled until the previous item is finished
// reset: window returns to [0,65536) on both axes; a clearing pass over ROWS*COLS
//   cells zeroes both mask memories while input is stalled
`timescale 1ns / 1ps
module uniform_grid_spatial_index #(
    parameter int ROWS        = ugsi_pkg::ROWS_DEFAULT,
    parameter int COLS        = ugsi_pkg::COLS_DEFAULT,
    parameter int MAX_OBJECTS = ugsi_pkg::MAX_OBJ_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  ugsi_pkg::ugsi_in_t             in_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ugsi_pkg::ugsi_out_t            out_word,
    input  logic                           cfg_we,
    input  logic [ugsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ugsi_pkg::COORD_W-1:0]   cfg_data
);

    // controller and datapath talk only through these two bundles
    ugsi_pkg::ugsi_cmd_t    cmd;
    ugsi_pkg::ugsi_status_t status;

    // sequencer: clear sweep, corner mapping, cell walk, id scan
    ugsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // window registers, divider, mask memories, accumulator and output word
    ugsi_dp #(
        .ROWS        (ROWS),
        .COLS        (COLS),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_word   (in_word),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// File: hw/rtl/ugsi_checker.sv
`timescale 1ns / 1ps
`include "uniform_grid_spatial_index_assert.svh"
module ugsi_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  ugsi_pkg::ugsi_in_t             in_word,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  ugsi_pkg::ugsi_out_t            out_word
);

    // stalled input word holds
    `UGSI_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_word))
    // stalled word holds
    `UGSI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
    // a miss is the only word of its query
    `UGSI_ASSERT_NOW(a_miss_last, out_valid && !out_word.found, out_word.is_last)
    // a miss carries id zero
    `UGSI_ASSERT_NOW(a_miss_zero, out_valid && !out_word.found, out_word.found_id == 5'd0)
    // ids of one query rise
    `UGSI_ASSERT_NEXT(a_ids_rise, out_valid && !out_stall && !out_word.is_last,
                      !out_valid || (out_word.found_id > $past(out_word.found_id)))

endmodule

bind uniform_grid_spatial_index ugsi_checker u_checker (.*);
